[rtl/rwtc_pkg.sv]
// shared types and constants for the replay window token check
// no dependencies; used by the top level, rwtc_alu and the testbench
package rwtc_pkg;

  localparam int TOKEN_W   = 32;  // token and window start width
  localparam int WM_W      = 13;  // watermark register width
  localparam int DIST_W    = 14;  // signed distance from start to token
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_WATERMARK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_WATERMARK = 2'd2;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

[rtl/replay_window_token_check.sv]
// top level of the sliding-window replay check for one-time tokens
// depends on rwtc_pkg, rwtc_alu and rwtc_marks
//
// usage:
//   in channel (in_valid/in_ready, token) takes one token per transaction.
//   out channel (out_valid/out_ready, accepted, current_start) returns one
//   result per token, in order.
//   cfg_we/cfg_index/cfg_data write window_start (0), low_watermark (1) and
//   high_watermark (2); other indexes are ignored. writes must go in while idle (not enforced).
// flow: a token outside the window or already spent goes through IDLE, CHECK,
//   LOOK and EMIT into the output register; an accepted token also passes
//   SLIDE between LOOK and EMIT, where n is the number of slots the window slides,
//   one slot per cycle through the shared adder and the single mark port.
//   in_ready is low meanwhile, until EMIT has loaded the output register.
// reset and window_start writes run a clearing pass over the spent marks,
//   during which in_ready stays low.
// a stalled receiver holds the result in the output register; the next
//   token is taken and worked on, and waits to finish until the register
//   frees up.
module replay_window_token_check #(
  parameter int WINDOW = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rwtc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rwtc_pkg::TOKEN_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rwtc_pkg::TOKEN_W-1:0]        token,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                accepted,
  output logic [rwtc_pkg::TOKEN_W-1:0]        current_start
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int TW = rwtc_pkg::TOKEN_W;
  localparam int DW = rwtc_pkg::DIST_W;

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    LOOK,
    SLIDE,
    EMIT
  } state_t;

  state_t                       state;
  logic [TW-1:0]                start;
  logic [AW-1:0]                offset;
  logic [TW-1:0]                tok;
  logic signed [DW-1:0]         span;
  logic                         in_win;
  logic [AW-1:0]                slot;
  logic                         bypass;
  logic                         ok;
  logic [rwtc_pkg::WM_W-1:0]    low_wm;
  logic [rwtc_pkg::WM_W-1:0]    high_wm;

  rwtc_pkg::alu_op_t            alu_op;
  logic [TW-1:0]                alu_a;
  logic [TW-1:0]                alu_b;
  logic [TW-1:0]                alu_y;

  logic                         mark_we;
  logic [AW-1:0]                mark_waddr;
  logic                         mark_wdata;
  logic [AW-1:0]                mark_raddr;
  logic                         mark_rdata;
  logic                         mark_busy;
  logic                         start_write;

  logic [AW:0]                  slot_sum;
  logic [AW-1:0]                slot_next;
  logic [AW-1:0]                offset_inc;
  logic                         head_spent;
  logic                         force_slide;
  logic                         retire_slide;
  logic                         step;
  logic                         out_free;

  assign start_write = cfg_we && (cfg_index == rwtc_pkg::REG_WINDOW_START);
  assign in_ready    = (state == IDLE) && !mark_busy;
  assign out_free    = !out_valid || out_ready;

  // shared unit: distance to the token in CHECK, start increment otherwise
  always_comb begin
    if (state == CHECK) begin
      alu_op = rwtc_pkg::ALU_SUB;
      alu_a  = tok;
      alu_b  = start;
    end else begin
      alu_op = rwtc_pkg::ALU_ADD;
      alu_a  = start;
      alu_b  = TW'(1);
    end
  end

  rwtc_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .result (alu_y)
  );

  // ring slot of the token, valid only when it lies in the window
  assign slot_sum   = {1'b0, offset} + {1'b0, alu_y[AW-1:0]};
  assign slot_next  = (slot_sum >= (AW+1)'(WINDOW)) ? AW'(slot_sum - (AW+1)'(WINDOW))
                                                   : slot_sum[AW-1:0];
  assign offset_inc = (offset == AW'(WINDOW - 1)) ? '0 : offset + AW'(1);

  assign head_spent   = bypass || mark_rdata;
  assign force_slide  = span >= $signed({1'b0, high_wm});
  assign retire_slide = (span >= $signed({1'b0, low_wm})) && head_spent;
  assign step         = (state == SLIDE) && (force_slide || retire_slide);

  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = offset;
    mark_wdata = 1'b0;
    mark_raddr = offset;
    unique case (state)
      CHECK: mark_raddr = slot_next;
      LOOK: begin
        mark_we    = in_win && !mark_rdata;
        mark_waddr = slot;
        mark_wdata = 1'b1;
        mark_raddr = offset;
      end
      SLIDE: begin
        mark_we    = step;
        mark_waddr = offset;
        mark_wdata = 1'b0;
        mark_raddr = offset_inc;
      end
      default: mark_raddr = offset;
    endcase
  end

  rwtc_marks #(
    .WINDOW (WINDOW),
    .AW     (AW)
  ) u_marks (
    .clk   (clk),
    .rst   (rst),
    .clear (start_write),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (mark_raddr),
    .rdata (mark_rdata),
    .busy  (mark_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      start     <= '0;
      offset    <= '0;
      low_wm    <= '0;
      high_wm   <= '0;
      out_valid <= 1'b0;
      bypass    <= 1'b0;
      ok        <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid && in_ready) begin
            tok   <= token;
            state <= CHECK;
          end
        end
        CHECK: begin
          in_win <= alu_y < TW'(WINDOW);
          span   <= alu_y[DW-1:0];
          slot   <= slot_next;
          state  <= LOOK;
        end
        LOOK: begin
          if (in_win && !mark_rdata) begin
            ok     <= 1'b1;
            bypass <= slot == offset;
            state  <= SLIDE;
          end else begin
            ok    <= 1'b0;
            state <= EMIT;
          end
        end
        SLIDE: begin
          if (step) begin
            start  <= alu_y;
            offset <= offset_inc;
            span   <= span - DW'(1);
            bypass <= 1'b0;
          end else begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            accepted      <= ok;
            current_start <= start;
            state         <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          rwtc_pkg::REG_WINDOW_START: begin
            start  <= cfg_data;
            offset <= '0;
          end
          rwtc_pkg::REG_LOW_WATERMARK:  low_wm  <= cfg_data[rwtc_pkg::WM_W-1:0];
          rwtc_pkg::REG_HIGH_WATERMARK: high_wm <= cfg_data[rwtc_pkg::WM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // one token at a time
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a token is in flight");

  // the slide never runs more than one slot past the token
  assert property (@(posedge clk) disable iff (rst)
    (state == SLIDE) |-> (span >= $signed({DW{1'b1}})))
    else $error("window slid past the token");

  // the ring offset moves only on a slide step or a window start write
  assert property (@(posedge clk) disable iff (rst)
    ##1 !$stable(offset) |-> ($past(step) || $past(start_write)))
    else $error("ring offset changed outside a slide");

endmodule

[rtl/rwtc_alu.sv]
// shared 32-bit add/subtract unit of the token check sequencer
// depends on rwtc_pkg
module rwtc_alu (
  input  rwtc_pkg::alu_op_t                 op,
  input  logic [rwtc_pkg::TOKEN_W-1:0]      a,
  input  logic [rwtc_pkg::TOKEN_W-1:0]      b,
  output logic [rwtc_pkg::TOKEN_W-1:0]      result
);

  always_comb begin
    unique case (op)
      rwtc_pkg::ALU_ADD: result = a + b;
      rwtc_pkg::ALU_SUB: result = a - b;
      default:           result = a + b;
    endcase
  end

endmodule

[rtl/rwtc_marks.sv]
// spent-mark memory, one bit per window slot, with a clearing sweep
// takes its widths as parameters from the top level; does not use rwtc_pkg
module rwtc_marks #(
  parameter int WINDOW = 64,
  parameter int AW     = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata,
  output logic          busy
);

  logic          mem [WINDOW];
  logic [AW-1:0] sweep;
  logic          clearing;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      clearing <= 1'b1;
      sweep    <= '0;
    end else if (clearing) begin
      if (sweep == AW'(WINDOW - 1)) begin
        clearing <= 1'b0;
      end else begin
        sweep <= sweep + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && clearing) begin
      mem[sweep] <= 1'b0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign busy = clearing;

endmodule

[dv/replay_window_token_check_tb.sv]
`timescale 1ns / 1ps
// testbench for replay_window_token_check: directed table, then random phases
// depends on rwtc_pkg and the replay_window_token_check rtl
module replay_window_token_check_tb;

  localparam int TOKEN_W   = rwtc_pkg::TOKEN_W;
  localparam int CFG_IDX_W = rwtc_pkg::CFG_IDX_W;
  localparam int WM_W      = rwtc_pkg::WM_W;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START   = rwtc_pkg::REG_WINDOW_START;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_WATERMARK  = rwtc_pkg::REG_LOW_WATERMARK;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_WATERMARK = rwtc_pkg::REG_HIGH_WATERMARK;

  localparam int WINDOW          = 64;
  localparam int POS_W           = $clog2(WINDOW);
  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 9;
  localparam int IDLE_GAP        = 8;    // longest rejected-token latency, with margin
  localparam int DRAIN_CYCLES    = 80;   // accepted token may slide the whole window
  localparam int LONG_STALL      = 300;
  localparam int NUM_PHASES      = 14;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int TIMEOUT_CYCLES  = 1_000_000;
  localparam logic [TOKEN_W-1:0] HALF_RANGE = 32'h8000_0000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef enum logic {ROW_WRITE, ROW_TOKEN} row_kind_t;

  // token rows use value as the token; typed rows carry a hand-worked result
  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [TOKEN_W-1:0]   value;
    logic                 typed;
    logic                 ok;
    logic [TOKEN_W-1:0]   start_num;
  } dir_row_t;

  typedef struct packed {
    logic               ok;
    logic [TOKEN_W-1:0] start_num;
  } verdict_t;

  localparam int NUM_ROWS = 31;
  localparam dir_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
    // after reset: start 0, both watermarks 0, so every accept slides past the token
    '{ROW_TOKEN, REG_WINDOW_START,   32'h0000_0000, 1'b1, 1'b1, 32'd1},
    '{ROW_TOKEN, REG_WINDOW_START,   32'h0000_0000, 1'b1, 1'b0, 32'd1},
    '{ROW_TOKEN, REG_WINDOW_START,   32'h0000_0040, 1'b1, 1'b1, 32'd65},
    '{ROW_TOKEN, REG_WINDOW_START,   32'h0000_0081, 1'b1, 1'b0, 32'd65},
    '{ROW_TOKEN, REG_WINDOW_START,   32'hFFFF_FFFF, 1'b1, 1'b0, 32'd65},
    '{ROW_TOKEN, REG_WINDOW_START,   32'h8000_0041, 1'b1, 1'b0, 32'd65},
    // watermarks beyond the window: nothing ever slides
    '{ROW_WRITE, REG_WINDOW_START,   32'hFFFF_FFF0, 1'b0, 1'b0, 32'd0},
    '{ROW_WRITE, REG_LOW_WATERMARK,  32'd4096,      1'b0, 1'b0, 32'd0},
    '{ROW_WRITE, REG_HIGH_WATERMARK, 32'd4096,      1'b0, 1'b0, 32'd0},
    '{ROW_TOKEN, REG_WINDOW_START,   32'hFFFF_FFF0, 1'b1, 1'b1, 32'hFFFF_FFF0},
    '{ROW_TOKEN, REG_WINDOW_START,   32'hFFFF_FFF0, 1'b1, 1'b0, 32'hFFFF_FFF0},
    '{ROW_TOKEN, REG_WINDOW_START,   32'h0000_002F, 1'b1, 1'b1, 32'hFFFF_FFF0},
    '{ROW_TOKEN, REG_WINDOW_START,   32'h0000_0030, 1'b1, 1'b0, 32'hFFFF_FFF0},
    '{ROW_TOKEN, REG_WINDOW_START,   32'hFFFF_FFEF, 1'b1, 1'b0, 32'hFFFF_FFF0},
    // retire spent leading slots only
    '{ROW_WRITE, REG_LOW_WATERMARK,  32'd0,         1'b0, 1'b0, 32'd0},
    '{ROW_TOKEN, REG_WINDOW_START,   32'hFFFF_FFF1, 1'b0, 1'b0, 32'd0},
    '{ROW_TOKEN, REG_WINDOW_START,   32'hFFFF_FFF5, 1'b0, 1'b0, 32'd0},
    '{ROW_WRITE, REG_HIGH_WATERMARK, 32'd1,         1'b0, 1'b0, 32'd0},
    '{ROW_TOKEN, REG_WINDOW_START,   32'hFFFF_FFF2, 1'b0, 1'b0, 32'd0},
    '{ROW_WRITE, REG_UNMAPPED,       32'h0000_1FFF, 1'b0, 1'b0, 32'd0},
    '{ROW_TOKEN, REG_WINDOW_START,   32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0},
    // window straddling the serial half-range boundary
    '{ROW_WRITE, REG_WINDOW_START,   32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0},
    '{ROW_TOKEN, REG_WINDOW_START,   32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0},
    '{ROW_TOKEN, REG_WINDOW_START,   32'h8000_003F, 1'b0, 1'b0, 32'd0},
    '{ROW_TOKEN, REG_WINDOW_START,   32'h8000_0040, 1'b0, 1'b0, 32'd0},
    '{ROW_WRITE, REG_WINDOW_START,   32'h0000_0000, 1'b0, 1'b0, 32'd0},
    '{ROW_WRITE, REG_HIGH_WATERMARK, 32'd64,        1'b0, 1'b0, 32'd0},
    '{ROW_TOKEN, REG_WINDOW_START,   32'h0000_003F, 1'b0, 1'b0, 32'd0},
    // forced slide across the full window
    '{ROW_WRITE, REG_HIGH_WATERMARK, 32'd0,         1'b0, 1'b0, 32'd0},
    '{ROW_TOKEN, REG_WINDOW_START,   32'h0000_0000, 1'b0, 1'b0, 32'd0},
    '{ROW_TOKEN, REG_WINDOW_START,   32'h0000_0040, 1'b0, 1'b0, 32'd0}
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TOKEN_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [TOKEN_W-1:0]   token;
  logic                 out_valid;
  logic                 out_ready;
  logic                 accepted;
  logic [TOKEN_W-1:0]   current_start;

  // window tracking state
  logic [TOKEN_W-1:0] win_start;
  logic [POS_W-1:0]   ring_pos;
  logic               spent_slot [0:WINDOW-1];
  logic [WM_W-1:0]    low_mark;
  logic [WM_W-1:0]    high_mark;

  verdict_t           pending_verdicts[$];
  logic [TOKEN_W-1:0] recent_tokens[$];
  int                 mismatches;

  // sender-side hints read by the monitor and the receiver
  logic               typed_row;
  logic               typed_ok;
  logic [TOKEN_W-1:0] typed_start;
  logic               quiet;
  logic               hold_request;

  replay_window_token_check #(
    .WINDOW(WINDOW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .token(token),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .accepted(accepted),
    .current_start(current_start)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  function automatic logic at_or_before(logic [TOKEN_W-1:0] a, logic [TOKEN_W-1:0] b);
    logic [TOKEN_W-1:0] gap;
    gap = b - a;
    return gap < HALF_RANGE;
  endfunction

  function automatic void clear_window();
    ring_pos = '0;
    for (int i = 0; i < WINDOW; i++) spent_slot[i] = 1'b0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [TOKEN_W-1:0] data);
    case (idx)
      REG_WINDOW_START: begin
        win_start = data;
        clear_window();
      end
      REG_LOW_WATERMARK:  low_mark  = data[WM_W-1:0];
      REG_HIGH_WATERMARK: high_mark = data[WM_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic verdict_t judge_token(logic [TOKEN_W-1:0] tok);
    verdict_t           v;
    logic [TOKEN_W-1:0] offset_in;
    logic [POS_W-1:0]   slot;
    logic               must_slide;
    logic               can_retire;
    v.ok = 1'b0;
    offset_in = tok - win_start;
    // offset below WINDOW is the same as start <= tok < start + WINDOW in serial order
    if (offset_in < WINDOW) begin
      slot = ring_pos + offset_in[POS_W-1:0];
      if (!spent_slot[slot]) begin
        spent_slot[slot] = 1'b1;
        v.ok = 1'b1;
        for (int n = 0; n <= WINDOW; n++) begin
          must_slide = at_or_before(win_start + high_mark, tok);
          can_retire = at_or_before(win_start + low_mark, tok) && spent_slot[ring_pos];
          if (!must_slide && !can_retire) break;
          spent_slot[ring_pos] = 1'b0;
          win_start = win_start + 1;
          ring_pos = ring_pos + 1'b1;
        end
      end
    end
    v.start_num = win_start;
    return v;
  endfunction

  function automatic void note_mismatch(string what, logic [TOKEN_W-1:0] want,
                                        logic [TOKEN_W-1:0] got);
    if (mismatches < 10)
      $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $time);
    mismatches++;
  endfunction

  // result check first, then config, then the new transaction, all on pre-edge values
  always @(posedge clk) begin
    verdict_t v;
    verdict_t want;
    if (rst) begin
      low_mark = '0;
      high_mark = '0;
      win_start = '0;
      clear_window();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          note_mismatch("unexpected result start", '0, current_start);
        end else begin
          want = pending_verdicts.pop_front();
          if (accepted !== want.ok)
            note_mismatch("accepted", TOKEN_W'(want.ok), TOKEN_W'(accepted));
          if (current_start !== want.start_num)
            note_mismatch("current_start", want.start_num, current_start);
        end
      end
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        v = judge_token(token);
        if (v.ok) begin
          recent_tokens.push_back(token);
          if (recent_tokens.size() > 16) void'(recent_tokens.pop_front());
        end
        if (typed_row) begin
          want.ok = typed_ok;
          want.start_num = typed_start;
          pending_verdicts.push_back(want);
        end else begin
          pending_verdicts.push_back(v);
        end
      end
    end
  end

  // receiver: random hold-off per result, plus one long stall on request
  initial begin
    int   n;
    logic stalled;
    out_ready = 1'b0;
    stalled = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request && !stalled) begin
        out_ready = 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        stalled = 1'b1;
      end
      n = quiet ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_token(input logic [TOKEN_W-1:0] tok, input logic typed,
                            input logic ok, input logic [TOKEN_W-1:0] start_num);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    token = tok;
    typed_row = typed;
    typed_ok = ok;
    typed_start = start_num;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic settle();
    in_valid = 1'b0;
    typed_row = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOKEN_W-1:0] data);
    settle();
    // clearing pass after reset or a start write keeps in_ready low
    while (!in_ready) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [TOKEN_W-1:0] pick_start();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return HALF_RANGE - $urandom_range(0, 80);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 80);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TOKEN_W-1:0] pick_mark();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 4096;
      2: return $urandom_range(1, 8);
      3: return $urandom_range(0, WINDOW);
      4: return $urandom_range(WINDOW - 4, WINDOW + 6);
      default: return $urandom_range(0, 4096);
    endcase
  endfunction

  // mostly in-window tokens, with replays, near misses and far-off noise
  function automatic logic [TOKEN_W-1:0] next_token();
    case ($urandom_range(0, 19))
      12, 13: begin
        if (recent_tokens.size() != 0)
          return recent_tokens[$urandom_range(0, recent_tokens.size() - 1)];
        return win_start;
      end
      14: return win_start - $urandom_range(1, 8);
      15: return win_start + WINDOW + $urandom_range(0, 8);
      16, 17: return $urandom;
      18, 19: return win_start + HALF_RANGE + $urandom_range(0, 2) - 1;
      default: return win_start + $urandom_range(0, WINDOW - 1);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    token = '0;
    typed_row = 1'b0;
    typed_ok = 1'b0;
    typed_start = '0;
    quiet = 1'b0;
    hold_request = 1'b0;
    mismatches = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_WRITE)
        write_reg(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].value);
      else
        send_token(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].typed,
                   DIRECTED_ROWS[r].ok, DIRECTED_ROWS[r].start_num);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 0 || $urandom_range(0, 1) == 1) write_reg(REG_WINDOW_START, pick_start());
      write_reg(REG_LOW_WATERMARK, pick_mark());
      write_reg(REG_HIGH_WATERMARK, pick_mark());
      if (phase == 5) write_reg(REG_UNMAPPED, $urandom);
      quiet = (phase % 4 == 1);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // long receiver stall while tokens keep coming
        if (phase == 3 && k == 20) hold_request = 1'b1;
        // sender pause until the pipeline is empty
        if (phase == 6 && k == 60) settle();
        send_token(next_token(), 1'b0, 1'b0, '0);
      end
      quiet = 1'b0;
    end

    in_valid = 1'b0;
    typed_row = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_verdicts.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
rtl/rwtc_pkg.sv
rtl/rwtc_alu.sv
rtl/rwtc_marks.sv
rtl/replay_window_token_check.sv
dv/replay_window_token_check_tb.sv
